[src/bsk_pkg.sv]
// ----------------------------------------------------------------------------
// bsk_pkg
// Shared constants and types for the bucketed sorted key lookup block.
// ----------------------------------------------------------------------------
package bsk_pkg;

    // table geometry
    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int BUCKETS         = 256;
    localparam int BKT_IDX_W       = 8;

    // field widths
    localparam int MODE_W   = 2;
    localparam int SLOT_W   = 12;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int START_W  = 13;
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 13;

    // largest storable bucket start
    localparam logic [START_W-1:0] START_MAX = '1;

    // input modes
    localparam logic [MODE_W-1:0] MODE_LOAD_ENTRY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_BUCKET = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP      = 2'd2;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_ENTRY_COUNT = 1'b0;

    // one table entry as stored
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] offset;
    } t_entry;

    // one lookup result
    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] data_offset;
        logic [INDEX_W-1:0] entry_index;
    } t_result;

endpackage

[src/bsk_if.sv]
// ----------------------------------------------------------------------------
// bsk_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface bsk_in_if;
    logic                         valid;
    logic                         ready;
    logic [bsk_pkg::MODE_W-1:0]   mode;
    logic [bsk_pkg::SLOT_W-1:0]   slot;
    logic [bsk_pkg::KEY_W-1:0]    key;
    logic [bsk_pkg::VALUE_W-1:0]  value;

    modport source (output valid, mode, slot, key, value, input ready);
    modport sink   (input valid, mode, slot, key, value, output ready);
endinterface

interface bsk_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [bsk_pkg::VALUE_W-1:0]  data_offset;
    logic [bsk_pkg::INDEX_W-1:0]  entry_index;

    modport source (output valid, found, data_offset, entry_index, input ready);
    modport sink   (input valid, found, data_offset, entry_index, output ready);
endinterface

[src/bsk_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bsk_cfg_regs
// APB register file holding the entry count.
// ----------------------------------------------------------------------------
module bsk_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bsk_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bsk_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bsk_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [bsk_pkg::COUNT_W-1:0]      o_entry_count
);
    import bsk_pkg::*;

    logic [COUNT_W-1:0] r_entry_count;
    logic               sel_count;

    // register decode, one word per 4 bytes
    assign sel_count = (paddr[2] == REG_IDX_ENTRY_COUNT);

    // entry count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (psel && penable && pwrite && sel_count) begin
            r_entry_count <= pwdata[COUNT_W-1:0];
        end
    end

    // read back
    assign prdata        = sel_count ? APB_DATA_W'(r_entry_count) : '0;
    assign pready        = 1'b1;
    assign o_entry_count = r_entry_count;

endmodule

[src/bsk_lookup_core.sv]
// ----------------------------------------------------------------------------
// bsk_lookup_core
// Entry and bucket memories with the load path and the binary search sequencer.
// ----------------------------------------------------------------------------
module bsk_lookup_core #(
    parameter int TABLE_DEPTH = bsk_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bsk_in_if.sink                        i_in,
    input  logic [bsk_pkg::COUNT_W-1:0]   i_entry_count,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output bsk_pkg::t_result              o_res
);
    import bsk_pkg::*;

    localparam int IW  = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DW  = $clog2(TABLE_DEPTH + 1);
    localparam int CW  = (DW > START_W) ? DW : START_W;
    localparam int SW  = (DW > SLOT_W) ? DW : SLOT_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_BOUND = 5'b00010,
        S_EDGE  = 5'b00100,
        S_MID   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // memories
    t_entry             r_entry_mem  [TABLE_DEPTH];
    logic [START_W-1:0] r_bucket_mem [BUCKETS];

    t_state             r_state, n_state;
    logic [KEY_W-1:0]   r_key;
    logic               r_last;
    logic [IW-1:0]      r_lo, n_lo;
    logic [IW-1:0]      r_hi, n_hi;
    t_result            r_res, n_res;

    logic [IW-1:0]        n_addr_a, n_addr_b;
    t_entry               r_ent_a, r_ent_b;
    logic [BKT_IDX_W-1:0] bkt_addr_a, bkt_addr_b;
    logic [START_W-1:0]   r_bkt_a, r_bkt_b;

    logic               accept;
    logic               ent_we, bkt_we;
    logic [IW-1:0]      ent_waddr;
    logic [START_W-1:0] bkt_wdata;

    logic [CW-1:0]      start_c, end_c, end_m1;
    logic [IW-1:0]      diff, mid_lo, mid_hi, mid_diff;

    function automatic logic [CW-1:0] clamp_depth(input logic [CW-1:0] v);
        return (v > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : v;
    endfunction

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;

    // load decode
    assign ent_we    = accept && (i_in.mode == MODE_LOAD_ENTRY)
                       && (SW'(i_in.slot) < SW'(TABLE_DEPTH));
    assign bkt_we    = accept && (i_in.mode == MODE_LOAD_BUCKET)
                       && (i_in.slot[SLOT_W-1:BKT_IDX_W] == '0);
    assign ent_waddr = IW'(i_in.slot);
    assign bkt_wdata = (|i_in.value[VALUE_W-1:START_W]) ? START_MAX
                                                       : i_in.value[START_W-1:0];

    // entry memory, one write port and two read ports
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_entry_mem[ent_waddr] <= '{key: i_in.key, offset: i_in.value};
        end
        r_ent_a <= r_entry_mem[n_addr_a];
        r_ent_b <= r_entry_mem[n_addr_b];
    end

    // bucket start memory, read at the bucket and its successor
    assign bkt_addr_a = i_in.key[KEY_W-1 -: BKT_IDX_W];
    assign bkt_addr_b = bkt_addr_a + BKT_IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (bkt_we) begin
            r_bucket_mem[i_in.slot[BKT_IDX_W-1:0]] <= bkt_wdata;
        end
        r_bkt_a <= r_bucket_mem[bkt_addr_a];
        r_bkt_b <= r_bucket_mem[bkt_addr_b];
    end

    // bucket bounds
    assign start_c = clamp_depth(CW'(r_bkt_a));
    assign end_c   = clamp_depth(r_last ? CW'(i_entry_count) : CW'(r_bkt_b));
    assign end_m1  = end_c - CW'(1);

    // range arithmetic
    assign diff = r_hi - r_lo;

    always_comb begin
        mid_lo = r_lo;
        mid_hi = r_hi;
        if (r_key < r_ent_a.key) begin
            mid_hi = r_lo + (diff >> 1);
        end else begin
            mid_lo = r_lo + (diff >> 1);
        end
    end
    assign mid_diff = mid_hi - mid_lo;

    // search sequencer
    always_comb begin
        n_state  = r_state;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_res    = r_res;
        n_addr_a = r_lo;
        n_addr_b = r_hi;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_in.mode == MODE_LOOKUP)) begin
                    n_state = S_BOUND;
                end
            end
            S_BOUND: begin
                n_res = '0;
                if (end_c > start_c) begin
                    n_lo     = start_c[IW-1:0];
                    n_hi     = end_m1[IW-1:0];
                    n_addr_a = start_c[IW-1:0];
                    n_addr_b = end_m1[IW-1:0];
                    n_state  = S_EDGE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_EDGE: begin
                // both ends are on the read ports
                if (r_ent_a.key == r_key) begin
                    n_res   = '{found: 1'b1, data_offset: r_ent_a.offset,
                                entry_index: INDEX_W'(r_lo)};
                    n_state = S_DONE;
                end else if (r_ent_b.key == r_key) begin
                    n_res   = '{found: 1'b1, data_offset: r_ent_b.offset,
                                entry_index: INDEX_W'(r_hi)};
                    n_state = S_DONE;
                end else if ((diff >> 1) == '0) begin
                    n_state = S_DONE;
                end else if ((r_key < r_ent_a.key) || (r_key > r_ent_b.key)) begin
                    n_state = S_DONE;
                end else begin
                    n_addr_a = r_lo + (diff >> 1);
                    n_state  = S_MID;
                end
            end
            S_MID: begin
                // midpoint entry is on port a; ends are known to differ from the key
                if (r_ent_a.key == r_key) begin
                    n_res   = '{found: 1'b1, data_offset: r_ent_a.offset,
                                entry_index: INDEX_W'(r_lo + (diff >> 1))};
                    n_state = S_DONE;
                end else begin
                    n_lo = mid_lo;
                    n_hi = mid_hi;
                    if ((mid_diff >> 1) == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_addr_a = mid_lo + (mid_diff >> 1);
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // search datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key  <= i_in.key;
            r_last <= (bkt_addr_a == '1);
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_res <= n_res;
    end

    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

[src/bucketed_sorted_key_lookup.sv]
// ----------------------------------------------------------------------------
// bucketed_sorted_key_lookup
// Sorted key table with a 256-way bucket index and a per-bucket binary search.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        word
//  i_in     in   valid/ready      mode, slot, key, value
//  o_out    out  valid/ready      found, data_offset, entry_index
//  apb      in   psel/penable     entry_count at byte address 0
//
//  Load words are written as they are accepted. A lookup reads the bucket
//  starts, then both ends of the bucket, then runs halving steps (up to
//  log2 of the bucket size), one per cycle, paced by the single read of the
//  entry memory per step; a lookup in an empty bucket skips the entry reads.
//  Reset clears control state only; memories hold nothing until loaded.
//  A result waits in the output register while the next word is taken; a
//  second lookup result waits in the core until the output drains.
// ----------------------------------------------------------------------------
module bucketed_sorted_key_lookup #(
    parameter int TABLE_DEPTH = bsk_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bsk_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bsk_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bsk_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    bsk_in_if.sink                           i_in,
    bsk_out_if.source                        o_out
);
    import bsk_pkg::*;

    logic [COUNT_W-1:0] entry_count;
    logic               res_valid;
    logic               res_ready;
    t_result            res;
    logic               r_ovalid;
    t_result            r_ores;

    // configuration registers
    bsk_cfg_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_entry_count (entry_count)
    );

    // memories and search
    bsk_lookup_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_entry_count (entry_count),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    // output register
    assign res_ready = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_ores <= res;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.found       = r_ores.found;
    assign o_out.data_offset = r_ores.data_offset;
    assign o_out.entry_index = r_ores.entry_index;

endmodule

[tb/tb_bucketed_sorted_key_lookup.sv]
// ----------------------------------------------------------------------------
// tb_bucketed_sorted_key_lookup
// Self-checking bench for the bucketed sorted key lookup block. It loads key
// tables and bucket starts, runs lookups against its own copy of the table
// search and compares every result word, field by field, in order.
// ----------------------------------------------------------------------------
module tb_bucketed_sorted_key_lookup;
    timeunit 1ns;
    timeprecision 1ps;

    import bsk_pkg::*;

    localparam int DEPTH         = TABLE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_WORDS  = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [MODE_W-1:0]     MODE_UNUSED      = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_ENTRY_COUNT = {REG_IDX_ENTRY_COUNT, 2'b00};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bsk_in_if  in_ch ();
    bsk_out_if out_ch ();

    bucketed_sorted_key_lookup u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // shadow copy of the block's tables and register; the tables are unknown until loaded
    logic [KEY_W-1:0]   key_tbl   [DEPTH];
    logic [VALUE_W-1:0] ofs_tbl   [DEPTH];
    logic [START_W-1:0] start_tbl [BUCKETS];
    logic [COUNT_W-1:0] count_reg;

    t_result     pending_results [$];
    int unsigned mismatch_cnt;
    int unsigned random_words;
    bit          count_words;
    int unsigned src_idle_odds;
    int unsigned sink_idle_odds;
    int unsigned hold_req;

    // clock
    initial i_clk = 1'b0;
    always #5ns i_clk = ~i_clk;

    // run limit
    initial begin
        #20ms;
        $display("bucketed_sorted_key_lookup: mismatch");
        $finish;
    end

    function automatic void note_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic int unsigned clamp_depth(input int unsigned v);
        return (v > DEPTH) ? DEPTH : v;
    endfunction

    // binary search of the bucket picked by the key's top byte; defined drops
    // when the search would touch a bucket start or entry never loaded
    function automatic t_result search_bucket(input logic [KEY_W-1:0] k,
                                              output bit defined);
        int unsigned bkt, lo, hi, mid, stop, at;
        bit          hit, done;
        t_result     r;
        r       = '0;
        hit     = 1'b0;
        done    = 1'b0;
        defined = 1'b1;
        at      = 0;
        lo      = 0;
        hi      = 0;
        stop    = 0;
        bkt     = k[31:24];
        if ($isunknown(start_tbl[bkt]) ||
            (bkt < BUCKETS - 1 && $isunknown(start_tbl[bkt + 1]))) begin
            defined = 1'b0;
            done    = 1'b1;
        end else begin
            lo = clamp_depth(start_tbl[bkt]);
            if (bkt < BUCKETS - 1) stop = clamp_depth(start_tbl[bkt + 1]);
            else stop = clamp_depth(count_reg);
            if (stop <= lo) done = 1'b1;
            else hi = stop - 1;
        end
        while (!done) begin
            if (lo >= DEPTH || hi >= DEPTH) begin
                done = 1'b1;
            end else if ($isunknown(key_tbl[lo])) begin
                defined = 1'b0; done = 1'b1;
            end else if (key_tbl[lo] == k) begin
                at = lo; hit = 1'b1; done = 1'b1;
            end else if ($isunknown(key_tbl[hi])) begin
                defined = 1'b0; done = 1'b1;
            end else if (key_tbl[hi] == k) begin
                at = hi; hit = 1'b1; done = 1'b1;
            end else if (hi < lo + 2) begin
                done = 1'b1;
            end else if (k < key_tbl[lo] || k > key_tbl[hi]) begin
                done = 1'b1;
            end else begin
                mid = lo + (hi - lo) / 2;
                if ($isunknown(key_tbl[mid])) begin
                    defined = 1'b0; done = 1'b1;
                end else if (k == key_tbl[mid]) begin
                    at = mid; hit = 1'b1; done = 1'b1;
                end else if (k < key_tbl[mid]) begin
                    hi = mid;
                end else begin
                    lo = mid;
                end
            end
        end
        if (hit) begin
            r.found       = 1'b1;
            r.data_offset = ofs_tbl[at];
            r.entry_index = at[INDEX_W-1:0];
        end
        return r;
    endfunction

    // apply one accepted word to the shadow tables
    function automatic void update_tables(input logic [MODE_W-1:0] mode,
                                          input logic [SLOT_W-1:0] slot,
                                          input logic [KEY_W-1:0] key,
                                          input logic [VALUE_W-1:0] value);
        bit defined;
        case (mode)
            MODE_LOAD_ENTRY: begin
                if (slot < DEPTH) begin
                    key_tbl[slot] = key;
                    ofs_tbl[slot] = value;
                end
            end
            MODE_LOAD_BUCKET: begin
                if (slot < BUCKETS)
                    start_tbl[slot[BKT_IDX_W-1:0]] =
                        (value > START_MAX) ? START_MAX : value[START_W-1:0];
            end
            MODE_LOOKUP: pending_results.push_back(search_bucket(key, defined));
            default: ;
        endcase
    endfunction

    // offer one word, optionally after an idle burst, and wait for acceptance
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                             input logic [KEY_W-1:0] key, input logic [VALUE_W-1:0] value);
        logic [MODE_W-1:0] m;
        bit                defined;
        m = mode;
        // a lookup into never-loaded table space goes out as an unused word
        if (m == MODE_LOOKUP) begin
            void'(search_bucket(key, defined));
            if (!defined) m = MODE_UNUSED;
        end
        if (src_idle_odds != 0 && $urandom_range(src_idle_odds - 1, 0) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(16, 1)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode  <= m;
        in_ch.slot  <= slot;
        in_ch.key   <= key;
        in_ch.value <= value;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        update_tables(m, slot, key, value);
        if (count_words && m != MODE_UNUSED && !(m == MODE_LOAD_BUCKET && slot >= BUCKETS))
            random_words++;
    endtask

    // sender stops and waits for every outstanding result
    task automatic pause_for_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // block fully idle: results drained and any trailing load finished
    task automatic quiesce();
        pause_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write followed by a read back
    task automatic set_entry_count(input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ENTRY_COUNT;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        count_reg = data[COUNT_W-1:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== {{(APB_DATA_W - COUNT_W){1'b0}}, count_reg})
            note_mismatch($sformatf("entry_count read back: expected %h, got %h",
                                    count_reg, readback));
    endtask

    // lookup key for a bucket: a stored key, a near miss or a random key in the bucket
    function automatic logic [KEY_W-1:0] bucket_key(input int unsigned b);
        int unsigned      lo, stop;
        logic [KEY_W-1:0] k;
        lo   = clamp_depth(start_tbl[b]);
        stop = (b < BUCKETS - 1) ? clamp_depth(start_tbl[b + 1]) : clamp_depth(count_reg);
        k    = {b[7:0], 24'($urandom)};
        if (stop > lo) begin
            k = key_tbl[$urandom_range(stop - 1, lo)];
            case ($urandom_range(5, 0))
                0: k = k + 1;
                1: k = k - 1;
                2: k[23:0] = 24'($urandom);
                default: ;
            endcase
        end
        if ($isunknown(k)) k = {b[7:0], 24'($urandom)};
        return k;
    endfunction

    // lookup key from any bucket, preferring one whose search is fully loaded
    function automatic logic [KEY_W-1:0] live_key();
        logic [KEY_W-1:0] k;
        bit               defined;
        k = bucket_key($urandom_range(BUCKETS - 1, 0));
        for (int n = 0; n < 64; n++) begin
            void'(search_bucket(k, defined));
            if (defined) break;
            k = bucket_key($urandom_range(BUCKETS - 1, 0));
        end
        return k;
    endfunction

    // stray or disruptive word
    task automatic send_noise();
        case ($urandom_range(4, 0))
            0: send_word(MODE_UNUSED, 12'($urandom), $urandom, $urandom);
            1: send_word(MODE_LOAD_BUCKET, 12'($urandom_range(4095, 256)), $urandom, $urandom);
            2: send_word(MODE_LOOKUP, 12'($urandom), $urandom, $urandom);
            3: send_word(MODE_LOAD_ENTRY, 12'($urandom), $urandom, $urandom);
            default: send_word(MODE_LOAD_BUCKET, 12'($urandom_range(255, 0)), $urandom,
                               $urandom_range(1, 0) ? $urandom : $urandom_range(4200, 0));
        endcase
    endtask

    // sorted keys for buckets first..last packed from entry base on
    task automatic load_window(input int unsigned base, input int unsigned first,
                               input int unsigned last, input int unsigned total,
                               input bit noisy);
        int unsigned b, idx, left, cnt, step_max, low;
        idx  = base;
        left = total;
        for (b = first; b <= last; b++) begin
            send_word(MODE_LOAD_BUCKET, SLOT_W'(b), $urandom, idx);
            if (b == last) begin
                cnt = left;
            end else begin
                cnt = $urandom_range(total / (last - first + 1), 0);
                if (cnt > left) cnt = left;
            end
            left     = left - cnt;
            step_max = 24'hFF_FFFF / (cnt + 1);
            low      = $urandom_range(step_max, 0);
            repeat (cnt) begin
                send_word(MODE_LOAD_ENTRY, SLOT_W'(idx), {b[7:0], low[23:0]}, $urandom);
                idx++;
                // an occasional duplicate key in noisy tables
                if (!(noisy && $urandom_range(15, 0) == 0)) low += $urandom_range(step_max, 1);
                if (noisy && $urandom_range(9, 0) == 0) send_noise();
            end
        end
        if (last < BUCKETS - 1) send_word(MODE_LOAD_BUCKET, SLOT_W'(last + 1), $urandom, idx);
    endtask

    // hand-built table: edge keys, single entry and empty buckets, ignored words
    task automatic test_directed();
        src_idle_odds  = 4;
        sink_idle_odds = 4;
        set_entry_count(32'd8);
        send_word(MODE_LOAD_BUCKET, 12'd0,   32'h0, 32'd0);
        send_word(MODE_LOAD_BUCKET, 12'd1,   32'h0, 32'd3);
        send_word(MODE_LOAD_BUCKET, 12'd2,   32'h0, 32'd4);
        send_word(MODE_LOAD_BUCKET, 12'd254, 32'h0, 32'd4);
        send_word(MODE_LOAD_BUCKET, 12'd255, 32'h0, 32'd4);
        send_word(MODE_LOAD_ENTRY, 12'd0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(MODE_LOAD_ENTRY, 12'd1, 32'h0000_0010, 32'h0000_0000);
        send_word(MODE_LOAD_ENTRY, 12'd2, 32'h00FF_FFFF, 32'h1234_5678);
        send_word(MODE_LOAD_ENTRY, 12'd3, 32'h0100_0005, 32'hA5A5_5A5A);
        send_word(MODE_LOAD_ENTRY, 12'd4, 32'hFF00_0000, 32'h0000_0001);
        send_word(MODE_LOAD_ENTRY, 12'd5, 32'hFF00_0001, 32'h8000_0000);
        send_word(MODE_LOAD_ENTRY, 12'd6, 32'hFF80_0000, 32'h7FFF_FFFF);
        send_word(MODE_LOAD_ENTRY, 12'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        // out of range bucket slot and unused mode must leave the tables alone
        send_word(MODE_LOAD_BUCKET, 12'hFFF, 32'hFFFF_FFFF, 32'd0);
        send_word(MODE_UNUSED, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(MODE_LOOKUP, 12'd0, 32'h0000_0000, 32'd0);
        send_word(MODE_LOOKUP, 12'd0, 32'h00FF_FFFF, 32'd0);
        send_word(MODE_LOOKUP, 12'd0, 32'h0000_0010, 32'd0);
        send_word(MODE_LOOKUP, 12'd0, 32'h0000_0008, 32'd0);
        send_word(MODE_LOOKUP, 12'd0, 32'h0100_0005, 32'd0);
        send_word(MODE_LOOKUP, 12'd0, 32'h0100_0006, 32'd0);
        send_word(MODE_LOOKUP, 12'd0, 32'hFE12_3456, 32'd0);
        send_word(MODE_LOOKUP, 12'd0, 32'hFF00_0000, 32'd0);
        send_word(MODE_LOOKUP, 12'd0, 32'hFF80_0000, 32'd0);
        send_word(MODE_LOOKUP, 12'd0, 32'hFFFF_FFFF, 32'd0);
        send_word(MODE_LOOKUP, 12'd0, 32'hFF7F_FFFF, 32'd0);
        quiesce();
    endtask

    // two large buckets for deep searches
    task automatic test_deep_table();
        src_idle_odds  = 8;
        sink_idle_odds = 8;
        set_entry_count(32'd200);
        load_window(0, 0, 1, 200, 1'b0);
        repeat (40)
            send_word(MODE_LOOKUP, 12'($urandom), bucket_key($urandom_range(1, 0)),
                      $urandom);
        quiesce();
    endtask

    // bucket bounds and entry_count past the table, wide bucket starts
    task automatic test_saturated_bounds();
        src_idle_odds  = 3;
        sink_idle_odds = 3;
        set_entry_count(32'h0000_1FFF);
        load_window(DEPTH - 56, 252, 255, 56, 1'b0);
        send_word(MODE_LOAD_BUCKET, 12'd253, $urandom, 32'hFFFF_FFFF);
        send_word(MODE_LOAD_BUCKET, 12'd254, $urandom, 32'd9000);
        repeat (30)
            send_word(MODE_LOOKUP, 12'($urandom), bucket_key($urandom_range(255, 252)), $urandom);
        quiesce();
        // empty last bucket
        set_entry_count(32'd0);
        repeat (6) send_word(MODE_LOOKUP, 12'($urandom), bucket_key(255), $urandom);
        quiesce();
    endtask

    // random tables in bucket windows, lookups mixed with stray words
    task automatic test_random_tables();
        int unsigned first, last, total, base;
        logic [APB_DATA_W-1:0] cnt;
        count_words  = 1'b1;
        while (random_words < RANDOM_WORDS) begin
            src_idle_odds  = $urandom_range(3, 0) * 3;
            sink_idle_odds = $urandom_range(3, 0) * 3;
            first = $urandom_range(BUCKETS - 1, 0);
            last  = first + $urandom_range(11, 0);
            if (last > BUCKETS - 1) last = BUCKETS - 1;
            total = ($urandom_range(15, 0) == 0) ? $urandom_range(160, 64)
                                                 : $urandom_range(48, 0);
            base  = $urandom_range(DEPTH - total, 0);
            case ($urandom_range(5, 0))
                0: cnt = 0;
                1: cnt = 32'h0000_1FFF;
                2: cnt = $urandom;
                3: cnt = DEPTH;
                default: cnt = base + total;
            endcase
            set_entry_count(cnt);
            load_window(base, first, last, total, 1'b1);
            repeat ($urandom_range(30, 8)) begin
                if ($urandom_range(9, 0) == 0) send_noise();
                else send_word(MODE_LOOKUP, 12'($urandom),
                               bucket_key($urandom_range(last, first)), $urandom);
                if ($urandom_range(19, 0) == 0) pause_for_results();
            end
            quiesce();
        end
        count_words = 1'b0;
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_stall();
        src_idle_odds  = 0;
        sink_idle_odds = 0;
        hold_req       = HOLD_CYCLES;
        repeat (40)
            send_word(MODE_LOOKUP, 12'($urandom), live_key(), $urandom);
        quiesce();
    endtask

    // back to back words with no idling on either side
    task automatic test_full_rate();
        src_idle_odds  = 0;
        sink_idle_odds = 0;
        repeat (120) begin
            if ($urandom_range(7, 0) == 0) send_noise();
            else send_word(MODE_LOOKUP, 12'($urandom), live_key(), $urandom);
        end
    endtask

    // receiver pacing: long hold on request, otherwise random stall bursts
    initial begin : sink_pacing
        int unsigned hold_left, stall_left;
        hold_left    = 0;
        stall_left   = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (sink_idle_odds != 0 && $urandom_range(sink_idle_odds - 1, 0) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(15, 0);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // result word check against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result got, want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.found       = out_ch.found;
            got.data_offset = out_ch.data_offset;
            got.entry_index = out_ch.entry_index;
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result word: found=%0b offset=%h index=%0d",
                                        got.found, got.data_offset, got.entry_index));
            end else begin
                want = pending_results.pop_front();
                if (got !== want)
                    note_mismatch($sformatf(
                        "result word: expected found=%0b offset=%h index=%0d, got found=%0b offset=%h index=%0d",
                        want.found, want.data_offset, want.entry_index,
                        got.found, got.data_offset, got.entry_index));
            end
        end
    end

    // main sequence
    initial begin
        mismatch_cnt   = 0;
        random_words   = 0;
        count_words    = 1'b0;
        src_idle_odds  = 0;
        sink_idle_odds = 0;
        hold_req       = 0;
        count_reg      = '0;
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.mode     <= '0;
        in_ch.slot     <= '0;
        in_ch.key      <= '0;
        in_ch.value    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_deep_table();
        test_saturated_bounds();
        test_random_tables();
        test_output_stall();
        test_full_rate();

        quiesce();
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("bucketed_sorted_key_lookup: match");
        else
            $display("bucketed_sorted_key_lookup: mismatch");
        $finish;
    end

endmodule
